// ----- sv/dede_pkg.sv -----
// ---------------------------------------------------------------------------
// dede_pkg - shared types and constants of the delta/escape distance encoder
// Command codes, field widths and the queue entry that passes front to back.
// ---------------------------------------------------------------------------
package dede_pkg;

    localparam int VALUE_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int WIN_W       = 24;
    localparam int LEN_W       = 5;
    localparam int NBYTES_W    = 2;

    // short form: one 0 bit plus an 8-bit zigzag code
    localparam logic [LEN_W-1:0] SHORT_LEN   = 5'd9;
    // escape form: one 1 bit plus the 16-bit literal value
    localparam logic [LEN_W-1:0] LITERAL_LEN = 5'd17;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Up to three finished bytes, left-aligned, and how many of them count.
    typedef struct packed {
        logic [WIN_W-1:0]    win;
        logic [NBYTES_W-1:0] nbytes;
    } t_entry;

endpackage

// ----- sv/dede_front.sv -----
// ---------------------------------------------------------------------------
// dede_front - delta, zigzag and bit packing stage
// Classifies each value as short code or escape, packs it behind the
// pending bits and hands the finished bytes to the queue.
// ---------------------------------------------------------------------------
module dede_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_cmd,
    input  logic [dede_pkg::VALUE_W-1:0]        i_qdist_value,
    output logic                                o_push,
    output dede_pkg::t_entry                    o_entry
);

    logic [dede_pkg::VALUE_W-1:0] r_prev, n_prev;
    logic [dede_pkg::PEND_W-1:0]  r_pend_bits, n_pend_bits;
    logic [dede_pkg::PCNT_W-1:0]  r_pend_cnt, n_pend_cnt;

    logic                         up;
    logic [dede_pkg::VALUE_W-1:0] d_up, d_dn;
    logic                         is_short;
    logic [dede_pkg::BYTE_W-1:0]  zcode;
    logic [16:0]                  code;
    logic [dede_pkg::LEN_W-1:0]   len;
    logic [dede_pkg::WIN_W-1:0]   packed_bits;
    logic [dede_pkg::LEN_W-1:0]   nbits;
    logic [dede_pkg::LEN_W-1:0]   shamt;
    logic [dede_pkg::PCNT_W-1:0]  rem;
    logic [dede_pkg::BYTE_W-1:0]  rem_mask;
    logic [dede_pkg::BYTE_W-1:0]  flush_byte;

    // Zigzag code and short/escape decision
    always_comb begin
        up       = (i_qdist_value >= r_prev);
        d_up     = i_qdist_value - r_prev;
        d_dn     = r_prev - i_qdist_value;
        is_short = up ? (d_up < 16'd128) : (d_dn <= 16'd128);
        zcode    = up ? {d_up[6:0], 1'b0} : ({d_dn[6:0], 1'b0} - 8'd1);
        code     = is_short ? {9'd0, zcode} : {1'b1, i_qdist_value};
        len      = is_short ? dede_pkg::SHORT_LEN : dede_pkg::LITERAL_LEN;
    end

    // Append the code behind the pending bits and left-align the window
    always_comb begin
        packed_bits = ({17'd0, r_pend_bits} << len) | {7'd0, code};
        nbits       = {2'd0, r_pend_cnt} + len;
        shamt       = 5'(dede_pkg::WIN_W) - nbits;
        rem         = nbits[2:0];
        rem_mask    = (8'd1 << rem) - 8'd1;
        flush_byte  = 8'({1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));
    end

    always_comb begin
        n_prev      = r_prev;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        o_push      = 1'b0;
        o_entry     = '0;
        if (i_cmd == dede_pkg::CMD_FLUSH) begin
            o_entry.win    = {flush_byte, 16'd0};
            o_entry.nbytes = (r_pend_cnt != '0) ? 2'd1 : 2'd0;
            o_push         = i_accept && (r_pend_cnt != '0);
            if (i_accept) begin
                n_prev      = '0;
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end
        end else begin
            o_entry.win    = packed_bits << shamt;
            o_entry.nbytes = nbits[4:3];
            o_push         = i_accept;
            if (i_accept) begin
                n_prev      = i_qdist_value;
                n_pend_bits = packed_bits[6:0] & rem_mask[6:0];
                n_pend_cnt  = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_prev      <= n_prev;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule

// ----- sv/dede_queue.sv -----
// ---------------------------------------------------------------------------
// dede_queue - short entry queue between front and back
// Circular buffer with a fill count; push and pop may share a cycle.
// ---------------------------------------------------------------------------
module dede_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dede_pkg::t_entry i_entry,
    input  logic             i_pop,
    output dede_pkg::t_entry o_entry,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dede_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- sv/dede_back.sv -----
// ---------------------------------------------------------------------------
// dede_back - byte emitter
// Loads one queue entry into the output register and sends its bytes,
// most significant first, one per transfer; flags the final byte.
// ---------------------------------------------------------------------------
module dede_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dede_pkg::t_entry              i_entry,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dede_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last
);

    logic                            r_valid, n_valid;
    logic [dede_pkg::WIN_W-1:0]      r_win, n_win;
    logic [dede_pkg::NBYTES_W-1:0]   r_left, n_left;
    logic                            done;

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_win[dede_pkg::WIN_W-1 -: dede_pkg::BYTE_W];
    assign o_last      = (r_left == 2'd1);

    // Current entry finishes on this transfer, or nothing is held
    assign done  = !r_valid || (i_out_ready && o_last);
    assign o_pop = done && !i_empty;

    always_comb begin
        n_valid = r_valid;
        n_win   = r_win;
        n_left  = r_left;
        if (o_pop) begin
            n_valid = 1'b1;
            n_win   = i_entry.win;
            n_left  = i_entry.nbytes;
        end else if (done) begin
            n_valid = 1'b0;
        end else if (i_out_ready) begin
            n_win  = r_win << dede_pkg::BYTE_W;
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// ----- sv/delta_escape_distance_encoder.sv -----
// ---------------------------------------------------------------------------
// delta_escape_distance_encoder - zigzag delta coder with escape literals
// Packs 16-bit quantized distances into an MSB-first byte stream.
// ---------------------------------------------------------------------------
// Each encode command takes the difference from the previous value of the
// chunk and zigzag-maps it; a code below 256 goes out as a 0 bit plus eight
// code bits, anything else as a 1 bit plus the 16-bit literal. Bits are
// packed MSB-first and every full byte is sent at once, so a value yields
// one to three bytes, the final one flagged with o_last. A flush command
// sends the partial byte zero-padded (if any bits are pending) and starts a
// new chunk with previous value zero. The front stage takes one command per
// cycle whenever the entry queue has room; the byte emitter sends one byte
// per cycle on the output channel while i_out_ready is high, so a value
// occupies the output for one transfer per byte it makes (1 to 3), and a
// flush with nothing pending is taken as a command and makes no output. A
// command's bytes are written into the entry queue and then loaded into the
// output register before they are presented. No clearing pass after reset.
module delta_escape_distance_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [dede_pkg::VALUE_W-1:0]        i_qdist_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dede_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_last
);

    logic             in_xfer;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    dede_pkg::t_entry q_wr_entry;
    dede_pkg::t_entry q_rd_entry;

    // Take a command whenever the queue can hold what it may produce
    assign o_in_ready = !q_full;
    assign in_xfer    = i_in_valid && o_in_ready;

    dede_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_cmd         (i_cmd),
        .i_qdist_value (i_qdist_value),
        .o_push        (q_push),
        .o_entry       (q_wr_entry)
    );

    dede_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dede_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_rd_entry),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // Never write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("entry pushed into full queue");

    // Every encode transfer produces at least one byte
    a_encode_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_cmd == dede_pkg::CMD_ENCODE)) |-> (q_push && q_wr_entry.nbytes != 2'd0))
        else $error("encode command produced no bytes");

    // A byte that is not the last of its group is always followed by another
    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("byte group cut short");

    // Nothing is popped while the queue is empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("entry popped from empty queue");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the delta/escape distance encoder
// Drives encode and flush commands through the input channel, models the
// zigzag delta coder and bit packer, and checks every output byte and its
// last flag against the modeled stream, with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int DIR_N      = 25;
    localparam int RAND_N     = 145;
    localparam int CALM_N     = 30;    // trailing commands with no gaps or stalls
    localparam int WDOG_LIMIT = 1000;
    localparam int DRAIN_CYC  = 8;

    typedef struct packed {
        logic [dede_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_coded_byte;

    // Directed row: when typed is set, the expected bytes are given here.
    typedef struct packed {
        logic                         cmd;
        logic [dede_pkg::VALUE_W-1:0] val;
        logic                         typed;
        logic [1:0]                   nb;
        logic [dede_pkg::BYTE_W-1:0]  b0;
        logic [dede_pkg::BYTE_W-1:0]  b1;
        logic [dede_pkg::BYTE_W-1:0]  b2;
    } t_stim_row;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         i_cmd         = dede_pkg::CMD_ENCODE;
    logic [dede_pkg::VALUE_W-1:0] i_qdist_value = '0;
    logic                         i_out_ready   = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [dede_pkg::BYTE_W-1:0]  o_out_byte;
    logic                         o_last;

    // model state of the coder
    logic [dede_pkg::VALUE_W-1:0] model_prev = '0;
    logic [dede_pkg::PEND_W-1:0]  model_bits = '0;
    logic [dede_pkg::PCNT_W-1:0]  model_cnt  = '0;

    t_coded_byte coded_bytes_q [$];

    logic in_gaps    = 1'b1;
    logic out_stalls = 1'b1;
    int   err_count  = 0;
    int   n_cmds     = 0;
    int   n_flush    = 0;
    int   n_escape   = 0;
    int   n_triple   = 0;
    int   n_checked  = 0;
    int   quiet_cyc  = 0;

    t_stim_row dir_rows [DIR_N] = '{
        // after reset: zero encodes as a short code of all zeros
        '{dede_pkg::CMD_ENCODE, 16'h0000, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_FLUSH,  16'h1234, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
        // flush with nothing pending: no bytes
        '{dede_pkg::CMD_FLUSH,  16'hFFFF, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        // full-scale step escapes to the literal
        '{dede_pkg::CMD_ENCODE, 16'hFFFF, 1'b1, 2'd2, 8'hFF, 8'hFF, 8'h00},
        '{dede_pkg::CMD_FLUSH,  16'h0000, 1'b1, 2'd1, 8'h80, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0001, 1'b1, 2'd1, 8'h01, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'hFFFF, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        // largest negative step
        '{dede_pkg::CMD_ENCODE, 16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        // +128 gives code 256 (escape), -128 gives 255 (short)
        '{dede_pkg::CMD_ENCODE, 16'h0080, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h007F, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_FLUSH,  16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        // seven short codes leave seven bits pending
        '{dede_pkg::CMD_ENCODE, 16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0005, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0003, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h000A, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0002, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0002, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h0001, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        // escape on top of seven pending bits: three bytes
        '{dede_pkg::CMD_ENCODE, 16'h8000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'h8000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_FLUSH,  16'h0000, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_ENCODE, 16'hAAAA, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{dede_pkg::CMD_FLUSH,  16'h5555, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
    };

    delta_escape_distance_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_qdist_value (i_qdist_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Advance the coder model by one command and return the bytes it emits.
    task automatic pack_distance(input logic cmd, input logic [dede_pkg::VALUE_W-1:0] val,
                                 output int nb, output logic [dede_pkg::BYTE_W-1:0] ob [3]);
        int          delta;
        int          zz;
        int          len;
        int          cnt;
        logic [31:0] acc;
        logic [31:0] code;
        logic [31:0] tmp;
        nb  = 0;
        acc = {25'd0, model_bits};
        cnt = int'(model_cnt);
        n_cmds++;
        if (cmd == dede_pkg::CMD_FLUSH) begin
            if (cnt > 0) begin
                tmp   = acc << (8 - cnt);
                ob[0] = tmp[dede_pkg::BYTE_W-1:0];
                nb    = 1;
            end
            model_prev = '0;
            model_bits = '0;
            model_cnt  = '0;
            n_flush++;
            return;
        end
        delta = $signed({16'd0, val}) - $signed({16'd0, model_prev});
        zz    = (delta >= 0) ? 2 * delta : -2 * delta - 1;
        if (zz < 256) begin
            code = zz;
            len  = int'(dede_pkg::SHORT_LEN);
        end else begin
            code = 32'h1_0000 | {16'd0, val};
            len  = int'(dede_pkg::LITERAL_LEN);
            n_escape++;
        end
        model_prev = val;
        acc = (acc << len) | code;
        cnt = cnt + len;
        while (cnt >= 8) begin
            tmp    = acc >> (cnt - 8);
            ob[nb] = tmp[dede_pkg::BYTE_W-1:0];
            nb++;
            cnt -= 8;
        end
        if (nb == 3) n_triple++;
        tmp        = acc & ((32'd1 << cnt) - 32'd1);
        model_bits = tmp[dede_pkg::PEND_W-1:0];
        model_cnt  = cnt[dede_pkg::PCNT_W-1:0];
    endtask

    task automatic queue_bytes(input int nb, input logic [dede_pkg::BYTE_W-1:0] ob [3]);
        t_coded_byte entry;
        for (int i = 0; i < nb; i++) begin
            entry.data = ob[i];
            entry.last = (i == nb - 1);
            coded_bytes_q.push_back(entry);
        end
    endtask

    // Present one command, hold it until transfer, then update the model.
    task automatic issue_cmd(input logic cmd, input logic [dede_pkg::VALUE_W-1:0] val,
                             output int nb, output logic [dede_pkg::BYTE_W-1:0] ob [3]);
        int gap;
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid    <= 1'b0;
                i_qdist_value <= dede_pkg::VALUE_W'($urandom_range(0, 65535));
            end
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_qdist_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        pack_distance(cmd, val, nb, ob);
    endtask

    // output side: random stall bursts until the calm tail
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (out_stalls && stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (out_stalls && $urandom_range(0, 3) == 0) begin
                stall_left  = $urandom_range(1, 5) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each transferred byte against the oldest modeled one
    always @(posedge i_clk) begin
        t_coded_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (coded_bytes_q.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h last %0b", o_out_byte, o_last));
            end else begin
                want = coded_bytes_q.pop_front();
                if (o_out_byte !== want.data || o_last !== want.last) begin
                    flag_error($sformatf("byte exp %02h/last %0b, got %02h/last %0b",
                                         want.data, want.last, o_out_byte, o_last));
                end
            end
        end
    end

    // watchdog: too long with no transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cyc = 0;
            end else begin
                quiet_cyc++;
            end
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d bytes outstanding",
                         quiet_cyc, coded_bytes_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int                           nb;
        int                           sel;
        int                           delta;
        logic                         cmd;
        logic [dede_pkg::VALUE_W-1:0] val;
        logic [dede_pkg::BYTE_W-1:0]  ob [3];
        logic [dede_pkg::BYTE_W-1:0]  typed_b [3];

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            issue_cmd(dir_rows[r].cmd, dir_rows[r].val, nb, ob);
            if (dir_rows[r].typed) begin
                typed_b[0] = dir_rows[r].b0;
                typed_b[1] = dir_rows[r].b1;
                typed_b[2] = dir_rows[r].b2;
                queue_bytes(dir_rows[r].nb, typed_b);
            end else begin
                queue_bytes(nb, ob);
            end
        end

        // mostly small steps around the previous value, so both sides of the
        // escape threshold are hit often; the rest are flushes and wild values
        for (int k = 0; k < RAND_N; k++) begin
            if (k >= RAND_N - CALM_N) begin
                in_gaps    = 1'b0;
                out_stalls = 1'b0;
            end
            sel = $urandom_range(0, 99);
            cmd = dede_pkg::CMD_ENCODE;
            if (sel < 10) begin
                cmd = dede_pkg::CMD_FLUSH;
                val = dede_pkg::VALUE_W'($urandom_range(0, 65535));
            end else if (sel < 60) begin
                delta = $urandom_range(0, 260);
                val   = model_prev + dede_pkg::VALUE_W'(delta - 130);
            end else if (sel < 70) begin
                val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                val = dede_pkg::VALUE_W'($urandom_range(0, 65535));
            end
            issue_cmd(cmd, val, nb, ob);
            queue_bytes(nb, ob);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (coded_bytes_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        while (coded_bytes_q.size() > 0) begin
            void'(coded_bytes_q.pop_front());
            flag_error("expected byte never arrived");
        end

        $display("Ran %0d commands: %0d flushes, %0d escape literals, %0d three-byte values.",
                 n_cmds, n_flush, n_escape, n_triple);
        $display("Compared %0d output bytes, %0d errors.", n_checked, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/dede_pkg.sv
sv/dede_front.sv
sv/dede_queue.sv
sv/dede_back.sv
sv/delta_escape_distance_encoder.sv
test/tb_top.sv
